// ----- rtl/tpsa_pkg.sv -----
// Shared types and codes of the two-pool slot allocator.
package tpsa_pkg;

  // Request codes; codes 6 and 7 are ignored
  typedef enum logic [2:0] {
    REQ_QUERY       = 3'd0,
    REQ_CLAIM_NAMED = 3'd1,
    REQ_CLAIM_REG   = 3'd2,
    REQ_CLAIM_STO   = 3'd3,
    REQ_CLAIM_ANY   = 3'd4,
    REQ_FREE        = 3'd5
  } req_t;

  // Result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_OOB  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // Register pool size after reset
  localparam logic [6:0] NUM_REGISTERS_RESET = 7'd16;

  // Slot numbers are 7 bits wide, so at most this many slots exist
  localparam int SLOT_SPACE = 128;

  // Controller states
  typedef enum logic [1:0] {
    IDLE,
    EVAL,
    COMMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture an accepted input beat
    logic eval;    // bounds check and search candidates
    logic commit;  // update marks and load the result register
  } cmd_t;

  // Index of the lowest set bit of a byte
  function automatic logic [2:0] first_one8(input logic [7:0] v);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        pos = 3'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ----- rtl/two_pool_slot_allocator.sv -----
// Top level of the two-pool slot allocator.
// Slots 0 .. R-1 are registers, where R is num_registers capped at MAX_REGISTERS;
// slots from R upward are storage slots, appended one at a time up to
// min(STORAGE_SLOTS, 128 - R) and kept until reset. Each request beat yields one
// result beat. A request passes through an evaluation step, which checks bounds
// and forms the free-slot candidates with per-byte group flags, and a commit step,
// which picks the lowest candidate and updates the mark bitmaps. The next request
// can be accepted in the commit cycle while the result side keeps up; none is
// accepted during evaluation. Write num_registers only while no request is in
// flight.
module two_pool_slot_allocator #(
  parameter int MAX_REGISTERS = 64,
  parameter int STORAGE_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // register pool size
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [6:0]  slot_index,
  input  logic [63:0] allowed_mask,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        flag,
  output logic [6:0]  granted_slot
);

  tpsa_pkg::cmd_t cmd;
  logic [6:0]     num_registers;

  // Hold the register pool size
  always_ff @(posedge clk) begin
    if (rst) begin
      num_registers <= tpsa_pkg::NUM_REGISTERS_RESET;
    end else if (cfg_we) begin
      num_registers <= cfg_wdata;
    end
  end

  tpsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tpsa_datapath #(
    .MAX_REGISTERS (MAX_REGISTERS),
    .STORAGE_SLOTS (STORAGE_SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .num_registers (num_registers),
    .req_type      (req_type),
    .slot_index    (slot_index),
    .allowed_mask  (allowed_mask),
    .status        (status),
    .flag          (flag),
    .granted_slot  (granted_slot)
  );

endmodule

// ----- rtl/tpsa_ctrl.sv -----
// Controller state machine of the slot allocator: handshakes and step sequencing.
module tpsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output tpsa_pkg::cmd_t cmd
);

  tpsa_pkg::state_t state;
  tpsa_pkg::state_t state_next;
  logic             can_commit;
  logic             accept;

  // Commit only when the result register is free or being drained
  assign can_commit = !out_valid || !out_stall;

  // Outputs
  always_comb begin
    in_stall = !((state == tpsa_pkg::IDLE) ||
                 ((state == tpsa_pkg::COMMIT) && can_commit));
    accept     = in_valid && !in_stall;
    cmd.load   = accept;
    cmd.eval   = (state == tpsa_pkg::EVAL);
    cmd.commit = (state == tpsa_pkg::COMMIT) && can_commit;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tpsa_pkg::IDLE: begin
        if (accept) begin
          state_next = tpsa_pkg::EVAL;
        end
      end
      tpsa_pkg::EVAL: begin
        state_next = tpsa_pkg::COMMIT;
      end
      tpsa_pkg::COMMIT: begin
        if (can_commit) begin
          state_next = accept ? tpsa_pkg::EVAL : tpsa_pkg::IDLE;
        end
      end
      default: begin
        state_next = tpsa_pkg::IDLE;
      end
    endcase
  end

  // Advance state and track the pending result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tpsa_pkg::IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/tpsa_datapath.sv -----
// Datapath of the slot allocator: mark bitmaps, candidate search and result register.
module tpsa_datapath #(
  parameter int MAX_REGISTERS = 64,
  parameter int STORAGE_SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  tpsa_pkg::cmd_t cmd,
  input  logic [6:0]     num_registers,
  input  logic [2:0]     req_type,
  input  logic [6:0]     slot_index,
  input  logic [63:0]    allowed_mask,
  output logic [1:0]     status,
  output logic           flag,
  output logic [6:0]     granted_slot
);

  // Reachable storage slots and derived widths
  localparam int SW   = (STORAGE_SLOTS < tpsa_pkg::SLOT_SPACE) ?
                        STORAGE_SLOTS : tpsa_pkg::SLOT_SPACE;
  localparam int MR   = MAX_REGISTERS;
  localparam int SUW  = $clog2(SW + 1);
  localparam int RIW  = (MR > 1) ? $clog2(MR) : 1;
  localparam int SIW  = (SW > 1) ? $clog2(SW) : 1;
  localparam int RGN  = (MR + 7) / 8;
  localparam int SGN  = (SW + 7) / 8;
  localparam int RGW  = (RGN > 1) ? $clog2(RGN) : 1;
  localparam int SGW  = (SGN > 1) ? $clog2(SGN) : 1;
  localparam int RCW  = RGN * 8;
  localparam int SCW  = SGN * 8;

  // Pool state
  logic [MR-1:0]  reg_marks;
  logic [SW-1:0]  sto_marks;
  logic [SUW-1:0] sto_in_use;

  // Captured request
  tpsa_pkg::req_t req;
  logic [6:0]     idx;
  logic [63:0]    mask;

  // Evaluation results
  logic [6:0]     r_q;
  logic           oob_q;
  logic           is_reg_q;
  logic           mark_q;
  logic [SIW-1:0] sto_off_q;
  logic           can_append_q;
  logic [RCW-1:0] reg_cand_q;
  logic [SCW-1:0] sto_cand_q;
  logic [RGN-1:0] reg_grp_q;
  logic [SGN-1:0] sto_grp_q;

  // Evaluation logic
  logic [6:0]     r_eff;
  logic [7:0]     room;
  logic [SUW-1:0] cap;
  logic [SUW-1:0] lim;
  logic [6:0]     sto_off;
  logic           is_reg;
  logic           oob;
  logic           mark;
  logic [RCW-1:0] reg_cand;
  logic [SCW-1:0] sto_cand;
  logic [RGN-1:0] reg_grp;
  logic [SGN-1:0] sto_grp;

  // Capture an accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req  <= tpsa_pkg::req_t'(req_type);
      idx  <= slot_index;
      mask <= allowed_mask;
    end
  end

  // Pool sizes, bounds check and the named mark
  always_comb begin
    r_eff   = (num_registers > 7'(MR)) ? 7'(MR) : num_registers;
    room    = 8'(tpsa_pkg::SLOT_SPACE) - {1'b0, r_eff};
    cap     = (room < 8'(SW)) ? SUW'(room) : SUW'(SW);
    lim     = (sto_in_use < cap) ? sto_in_use : cap;
    oob     = (9'(idx) >= (9'(r_eff) + 9'(sto_in_use)));
    is_reg  = (idx < r_eff);
    sto_off = idx - r_eff;
    mark    = is_reg ? reg_marks[idx[RIW-1:0]] : sto_marks[sto_off[SIW-1:0]];
  end

  // Free candidates and per-byte group flags
  always_comb begin
    reg_cand = '0;
    sto_cand = '0;
    for (int i = 0; i < MR; i++) begin
      reg_cand[i] = !reg_marks[i] && (7'(i) < r_eff) &&
                    ((req == tpsa_pkg::REQ_CLAIM_ANY) || mask[i]);
    end
    for (int i = 0; i < SW; i++) begin
      sto_cand[i] = !sto_marks[i] && (SUW'(i) < lim);
    end
    for (int g = 0; g < RGN; g++) begin
      reg_grp[g] = |reg_cand[g*8 +: 8];
    end
    for (int g = 0; g < SGN; g++) begin
      sto_grp[g] = |sto_cand[g*8 +: 8];
    end
  end

  // Hold evaluation results for the commit step
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      r_q          <= r_eff;
      oob_q        <= oob;
      is_reg_q     <= is_reg;
      mark_q       <= mark;
      sto_off_q    <= sto_off[SIW-1:0];
      can_append_q <= (sto_in_use < cap);
      reg_cand_q   <= reg_cand;
      sto_cand_q   <= sto_cand;
      reg_grp_q    <= reg_grp;
      sto_grp_q    <= sto_grp;
    end
  end

  // Commit logic
  logic [RGW-1:0] reg_g;
  logic [SGW-1:0] sto_g;
  logic [6:0]     reg_pos;
  logic [6:0]     sto_pos;
  logic           reg_found;
  logic           sto_found;
  logic [1:0]     res_status;
  logic           res_flag;
  logic [6:0]     res_slot;
  logic           reg_wr;
  logic [RIW-1:0] reg_wr_idx;
  logic           sto_wr;
  logic [SIW-1:0] sto_wr_idx;
  logic           mark_val;
  logic           grow;
  logic           take_reg;
  logic           take_sto;

  // Pick the lowest free candidate: first group, then first bit in it
  always_comb begin
    reg_g = '0;
    for (int g = RGN - 1; g >= 0; g--) begin
      if (reg_grp_q[g]) begin
        reg_g = RGW'(g);
      end
    end
    sto_g = '0;
    for (int g = SGN - 1; g >= 0; g--) begin
      if (sto_grp_q[g]) begin
        sto_g = SGW'(g);
      end
    end
    reg_found = |reg_grp_q;
    sto_found = |sto_grp_q;
    reg_pos   = 7'({reg_g, tpsa_pkg::first_one8(reg_cand_q[reg_g*8 +: 8])});
    sto_pos   = 7'({sto_g, tpsa_pkg::first_one8(sto_cand_q[sto_g*8 +: 8])});
  end

  // Decide the result and the mark update
  always_comb begin
    res_status = tpsa_pkg::STATUS_OK;
    res_flag   = 1'b0;
    res_slot   = 7'd0;
    reg_wr     = 1'b0;
    reg_wr_idx = idx[RIW-1:0];
    sto_wr     = 1'b0;
    sto_wr_idx = sto_off_q;
    mark_val   = 1'b1;
    grow       = 1'b0;
    take_reg   = 1'b0;
    take_sto   = 1'b0;
    case (req)
      tpsa_pkg::REQ_QUERY: begin
        if (oob_q) begin
          res_status = tpsa_pkg::STATUS_OOB;
        end else begin
          res_flag = mark_q;
        end
      end
      tpsa_pkg::REQ_CLAIM_NAMED: begin
        if (oob_q) begin
          res_status = tpsa_pkg::STATUS_OOB;
        end else if (!mark_q) begin
          res_flag = 1'b1;
          reg_wr   = is_reg_q;
          sto_wr   = !is_reg_q;
        end
      end
      tpsa_pkg::REQ_FREE: begin
        if (oob_q) begin
          res_status = tpsa_pkg::STATUS_OOB;
        end else begin
          mark_val = 1'b0;
          reg_wr   = is_reg_q;
          sto_wr   = !is_reg_q;
        end
      end
      tpsa_pkg::REQ_CLAIM_REG: begin
        if (reg_found) begin
          take_reg = 1'b1;
        end else begin
          res_status = tpsa_pkg::STATUS_FULL;
        end
      end
      tpsa_pkg::REQ_CLAIM_STO: begin
        take_sto = 1'b1;
      end
      tpsa_pkg::REQ_CLAIM_ANY: begin
        take_reg = reg_found;
        take_sto = !reg_found;
      end
      default: begin
      end
    endcase

    // Claim the first free register
    if (take_reg) begin
      res_slot   = reg_pos;
      reg_wr     = 1'b1;
      reg_wr_idx = reg_pos[RIW-1:0];
    end

    // Claim the first free storage slot, or append one
    if (take_sto) begin
      if (sto_found) begin
        res_slot   = r_q + sto_pos;
        sto_wr     = 1'b1;
        sto_wr_idx = sto_pos[SIW-1:0];
      end else if (can_append_q) begin
        res_slot   = r_q + 7'(sto_in_use);
        sto_wr     = 1'b1;
        sto_wr_idx = sto_in_use[SIW-1:0];
        grow       = 1'b1;
      end else begin
        res_status = tpsa_pkg::STATUS_FULL;
      end
    end
  end

  // Update marks and the storage fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_marks  <= '0;
      sto_marks  <= '0;
      sto_in_use <= '0;
    end else if (cmd.commit) begin
      if (reg_wr) begin
        reg_marks[reg_wr_idx] <= mark_val;
      end
      if (sto_wr) begin
        sto_marks[sto_wr_idx] <= mark_val;
      end
      if (grow) begin
        sto_in_use <= sto_in_use + SUW'(1);
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status       <= res_status;
      flag         <= res_flag;
      granted_slot <= res_slot;
    end
  end

endmodule
